// ===== sv/sstf_request_queue_top_assert.svh =====
// ----------------------------------------------------------------------------
// SSTF request queue assertion macros
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SSTF_REQUEST_QUEUE_TOP_ASSERT_SVH
`define SSTF_REQUEST_QUEUE_TOP_ASSERT_SVH

// same-cycle implication
`define SSTF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SSTF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/sstf_rq_pkg.sv =====
// ----------------------------------------------------------------------------
// SSTF request queue package
// Field widths, codes, entry layout and the seek distance function.
// ----------------------------------------------------------------------------
package sstf_rq_pkg;

  localparam int SECTOR_W = 48;
  localparam int TAG_W    = 8;
  localparam int COUNT_W  = 6;
  localparam int STATUS_W = 2;

  typedef enum logic {
    OP_ADD      = 1'b0,
    OP_DISPATCH = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISP,
    S_HEAD,
    S_SCAN,
    S_SHIFT,
    S_SHIFT_LAST,
    S_INSERT,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [SECTOR_W-1:0] sector;
    logic [TAG_W-1:0]    tag;
  } entry_t;

  function automatic logic [SECTOR_W-1:0] seek_dist(input logic [SECTOR_W-1:0] a,
                                                    input logic [SECTOR_W-1:0] b);
    logic [SECTOR_W-1:0] ab;
    logic [SECTOR_W-1:0] ba;
    ab = a - b;
    ba = b - a;
    return (a >= b) ? ab : ba;
  endfunction

endpackage

// ===== sv/sstf_rq_in_if.sv =====
// ----------------------------------------------------------------------------
// SSTF request queue input channel
// Valid/ready channel carrying add and dispatch transactions.
// ----------------------------------------------------------------------------
interface sstf_rq_in_if
  import sstf_rq_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                opcode;
  logic [SECTOR_W-1:0] req_sector;
  logic [TAG_W-1:0]    req_tag;

  modport source (output valid, output opcode, output req_sector, output req_tag,
                  input ready);
  modport sink   (input valid, input opcode, input req_sector, input req_tag,
                  output ready);
endinterface

// ===== sv/sstf_rq_out_if.sv =====
// ----------------------------------------------------------------------------
// SSTF request queue result channel
// Valid/ready channel carrying one result transaction per input transaction.
// ----------------------------------------------------------------------------
interface sstf_rq_out_if
  import sstf_rq_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                out_valid;
  logic [SECTOR_W-1:0] out_sector;
  logic [TAG_W-1:0]    out_tag;
  logic [COUNT_W-1:0]  queue_count;

  modport source (output valid, output status, output out_valid, output out_sector,
                  output out_tag, output queue_count, input ready);
  modport sink   (input valid, input status, input out_valid, input out_sector,
                  input out_tag, input queue_count, output ready);
endinterface

// ===== sv/sstf_rq_ram.sv =====
// ----------------------------------------------------------------------------
// SSTF request queue RAM
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sstf_rq_ram #(
  parameter int WIDTH = 56,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/sstf_request_queue_top.sv =====
// ----------------------------------------------------------------------------
// SSTF request queue
// Circular buffer in RAM kept in seek order; adds scan then shift up.
// Dispatch reads the head entry, then returns it; an empty or rejected transaction
// goes straight to the result. An add scans up to the new entry's place, then
// shifts the rest up; at the tail it writes the entry with no shift. The single RAM
// read port reads one entry per cycle.
// One transaction at a time; the next is taken while a result waits.
// Synchronous reset empties the queue and zeroes the last dispatched sector.
// ----------------------------------------------------------------------------
module sstf_request_queue_top
  import sstf_rq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  sstf_rq_in_if.sink     in_chan,
  sstf_rq_out_if.source  out_chan
);
  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW:0]   DEPTH_A = (AW+1)'(QUEUE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  state_t              state_r, state_nxt;
  op_t                 op_r, op_nxt;
  logic [SECTOR_W-1:0] sec_r, sec_nxt;
  logic [TAG_W-1:0]    tag_r, tag_nxt;
  logic [AW-1:0]       head_r, head_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [SECTOR_W-1:0] last_r, last_nxt;
  logic [SECTOR_W-1:0] prev_r, prev_nxt;
  logic [AW-1:0]       j_r, j_nxt;
  logic [AW-1:0]       pos_r, pos_nxt;
  logic [AW-1:0]       k_r, k_nxt;
  logic                wb_v_r, wb_v_nxt;
  status_t             status_r, status_nxt;
  logic                dsp_v_r, dsp_v_nxt;
  logic [SECTOR_W-1:0] dsp_sec_r, dsp_sec_nxt;
  logic [TAG_W-1:0]    dsp_tag_r, dsp_tag_nxt;
  logic                res_v_r, res_v_nxt;
  status_t             res_status_r, res_status_nxt;
  logic                res_dv_r, res_dv_nxt;
  logic [SECTOR_W-1:0] res_sec_r, res_sec_nxt;
  logic [TAG_W-1:0]    res_tag_r, res_tag_nxt;
  logic [COUNT_W-1:0]  res_count_r, res_count_nxt;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_wdata;
  entry_t        mem_rdata;

  logic          accept;
  op_t           in_op;
  logic          res_free;
  logic          is_empty;
  logic          is_full;
  logic [CW-1:0] cnt_m1;
  logic          near;
  logic          hit;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                         input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, head} + {1'b0, off};
    if (sum >= DEPTH_A) begin
      sum = sum - DEPTH_A;
    end
    return sum[AW-1:0];
  endfunction

  sstf_rq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign accept   = in_chan.valid && in_chan.ready;
  assign in_op    = op_t'(in_chan.opcode);
  assign res_free = !res_v_r || out_chan.ready;
  assign is_empty = (count_r == '0);
  assign is_full  = (count_r == DEPTH_C);
  assign cnt_m1   = count_r - CW'(1);
  assign near     = seek_dist(sec_r, last_r) < seek_dist(mem_rdata.sector, last_r);
  assign hit      = seek_dist(prev_r, mem_rdata.sector) > seek_dist(prev_r, sec_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_op == OP_DISPATCH) begin
            state_nxt = is_empty ? S_RESP : S_DISP;
          end else begin
            state_nxt = (is_full || is_empty) ? S_RESP : S_HEAD;
          end
        end
      end
      S_DISP: state_nxt = S_RESP;
      S_HEAD: begin
        if (near) begin
          state_nxt = S_SHIFT;
        end else if (count_r == CW'(1)) begin
          state_nxt = S_INSERT;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_nxt = S_SHIFT;
        end else if (j_r == cnt_m1[AW-1:0]) begin
          state_nxt = S_INSERT;
        end
      end
      S_SHIFT: begin
        if (k_r == pos_r) begin
          state_nxt = S_SHIFT_LAST;
        end
      end
      S_SHIFT_LAST: state_nxt = S_INSERT;
      S_INSERT:     state_nxt = S_RESP;
      S_RESP: begin
        if (res_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // handshake and RAM port control
  always_comb begin
    in_chan.ready = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = phys(head_r, pos_r);
    mem_wdata     = '{sector: sec_r, tag: tag_r};
    mem_raddr     = head_r;
    case (state_r)
      S_IDLE: begin
        in_chan.ready = 1'b1;
        if (accept && in_op == OP_ADD && is_empty) begin
          mem_we    = 1'b1;
          mem_waddr = head_r;
          mem_wdata = '{sector: in_chan.req_sector, tag: in_chan.req_tag};
        end
      end
      S_HEAD: mem_raddr = phys(head_r, AW'(1));
      S_SCAN: mem_raddr = phys(head_r, j_r + AW'(1));
      S_SHIFT: begin
        mem_raddr = phys(head_r, k_r);
        mem_we    = wb_v_r;
        mem_waddr = phys(head_r, k_r + AW'(2));
        mem_wdata = mem_rdata;
      end
      S_SHIFT_LAST: begin
        mem_we    = 1'b1;
        mem_waddr = phys(head_r, pos_r + AW'(1));
        mem_wdata = mem_rdata;
      end
      S_INSERT: mem_we = 1'b1;
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    op_nxt         = op_r;
    sec_nxt        = sec_r;
    tag_nxt        = tag_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    last_nxt       = last_r;
    prev_nxt       = prev_r;
    j_nxt          = j_r;
    pos_nxt        = pos_r;
    k_nxt          = k_r;
    wb_v_nxt       = wb_v_r;
    status_nxt     = status_r;
    dsp_v_nxt      = dsp_v_r;
    dsp_sec_nxt    = dsp_sec_r;
    dsp_tag_nxt    = dsp_tag_r;
    res_v_nxt      = res_v_r && !out_chan.ready;
    res_status_nxt = res_status_r;
    res_dv_nxt     = res_dv_r;
    res_sec_nxt    = res_sec_r;
    res_tag_nxt    = res_tag_r;
    res_count_nxt  = res_count_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt      = in_op;
          sec_nxt     = in_chan.req_sector;
          tag_nxt     = in_chan.req_tag;
          status_nxt  = ST_OK;
          dsp_v_nxt   = 1'b0;
          dsp_sec_nxt = '0;
          dsp_tag_nxt = '0;
          if (in_op == OP_DISPATCH) begin
            if (is_empty) begin
              status_nxt = ST_EMPTY;
            end
          end else if (is_full) begin
            status_nxt = ST_FULL;
          end else if (is_empty) begin
            count_nxt = CW'(1);
          end
        end
      end
      S_DISP: begin
        dsp_v_nxt   = 1'b1;
        dsp_sec_nxt = mem_rdata.sector;
        dsp_tag_nxt = mem_rdata.tag;
        last_nxt    = mem_rdata.sector;
        head_nxt    = phys(head_r, AW'(1));
        count_nxt   = cnt_m1;
      end
      S_HEAD: begin
        prev_nxt = mem_rdata.sector;
        j_nxt    = AW'(1);
        k_nxt    = cnt_m1[AW-1:0];
        wb_v_nxt = 1'b0;
        pos_nxt  = near ? '0 : AW'(1);
      end
      S_SCAN: begin
        prev_nxt = mem_rdata.sector;
        j_nxt    = j_r + AW'(1);
        k_nxt    = cnt_m1[AW-1:0];
        wb_v_nxt = 1'b0;
        pos_nxt  = hit ? j_r : count_r[AW-1:0];
      end
      S_SHIFT: begin
        wb_v_nxt = 1'b1;
        if (k_r != pos_r) begin
          k_nxt = k_r - AW'(1);
        end
      end
      S_INSERT: count_nxt = count_r + CW'(1);
      S_RESP: begin
        if (res_free) begin
          res_v_nxt      = 1'b1;
          res_status_nxt = status_r;
          res_dv_nxt     = dsp_v_r;
          res_sec_nxt    = dsp_sec_r;
          res_tag_nxt    = dsp_tag_r;
          res_count_nxt  = COUNT_W'(count_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      count_r <= '0;
      last_r  <= '0;
      res_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      last_r  <= last_nxt;
      res_v_r <= res_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    sec_r        <= sec_nxt;
    tag_r        <= tag_nxt;
    prev_r       <= prev_nxt;
    j_r          <= j_nxt;
    pos_r        <= pos_nxt;
    k_r          <= k_nxt;
    wb_v_r       <= wb_v_nxt;
    status_r     <= status_nxt;
    dsp_v_r      <= dsp_v_nxt;
    dsp_sec_r    <= dsp_sec_nxt;
    dsp_tag_r    <= dsp_tag_nxt;
    res_status_r <= res_status_nxt;
    res_dv_r     <= res_dv_nxt;
    res_sec_r    <= res_sec_nxt;
    res_tag_r    <= res_tag_nxt;
    res_count_r  <= res_count_nxt;
  end

  assign out_chan.valid       = res_v_r;
  assign out_chan.status      = res_status_r;
  assign out_chan.out_valid   = res_dv_r;
  assign out_chan.out_sector  = res_sec_r;
  assign out_chan.out_tag     = res_tag_r;
  assign out_chan.queue_count = res_count_r;

`include "sstf_request_queue_top_assert.svh"

  `SSTF_ASSERT_NOW(a_count_bound, 1'b1, count_r <= DEPTH_C, "queue count above depth")
  `SSTF_ASSERT_NEXT(a_empty_dispatch, accept && in_op == OP_DISPATCH && is_empty, state_r == S_RESP && status_r == ST_EMPTY && count_r == '0, "empty dispatch not reported")
  `SSTF_ASSERT_NEXT(a_insert_count, state_r == S_INSERT, count_r == $past(count_r) + CW'(1) && state_r == S_RESP, "insert did not grow queue")
  `SSTF_ASSERT_NEXT(a_dispatch_op, state_r == S_DISP, op_r == OP_DISPATCH && dsp_v_r && last_r == dsp_sec_r, "dispatch transaction lost")

endmodule
